// File: hw/rtl/swgc_pkg.sv
// Shared constants and types for the sliding-window C/G fraction block.
`default_nettype none

package swgc_pkg;

    localparam int WINDOW    = 20;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SEEN_W    = $clog2(WINDOW + 2);
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = $clog2(FRAC_W);
    localparam int COUNT_W   = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int SYMBOL_W  = 8;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_AT    = 2'd1,
        CLS_GC    = 2'd2
    } swgc_class_t;

    typedef struct packed {
        logic [CNT_W-1:0] gc;
        logic [CNT_W-1:0] at;
    } swgc_counts_t;

endpackage

`default_nettype wire

// File: hw/rtl/swgc_front.sv
// Front end: classifies each byte, keeps the class ring and running counts.
`default_nettype none

module swgc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [swgc_pkg::SYMBOL_W-1:0] symbol,
    input  wire logic                          new_sequence,
    output logic                               push,
    output swgc_pkg::swgc_counts_t             push_counts
);
    import swgc_pkg::*;

    function automatic swgc_class_t classify(input logic [SYMBOL_W-1:0] b);
        swgc_class_t c;
        unique case (b)
            8'h41, 8'h61, 8'h54, 8'h74: c = CLS_AT;
            8'h43, 8'h63, 8'h47, 8'h67: c = CLS_GC;
            default:                    c = CLS_OTHER;
        endcase
        return c;
    endfunction

    swgc_class_t         ring_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg, slot_next, base_slot;
    logic [SEEN_W-1:0]   seen_reg, seen_next, base_seen;
    logic [CNT_W-1:0]    gc_reg, gc_next, base_gc;
    logic [CNT_W-1:0]    at_reg, at_next, base_at;
    swgc_class_t         cls, old;

    always_comb
    begin
        cls       = classify(symbol);
        base_slot = new_sequence ? '0 : slot_reg;
        base_seen = new_sequence ? '0 : seen_reg;
        base_gc   = new_sequence ? '0 : gc_reg;
        base_at   = new_sequence ? '0 : at_reg;
        old       = new_sequence ? CLS_OTHER : ring_reg[slot_reg];

        gc_next = base_gc;
        at_next = base_at;
        if (old == CLS_AT && base_at != '0)
        begin
            at_next = base_at - CNT_W'(1);
        end
        else if (old == CLS_GC && base_gc != '0)
        begin
            gc_next = base_gc - CNT_W'(1);
        end
        if (cls == CLS_AT)
        begin
            at_next = at_next + CNT_W'(1);
        end
        else if (cls == CLS_GC)
        begin
            gc_next = gc_next + CNT_W'(1);
        end

        slot_next = (base_slot == SLOT_W'(WINDOW - 1)) ? '0 : base_slot + SLOT_W'(1);
        seen_next = (base_seen < SEEN_W'(WINDOW + 1)) ? base_seen + SEEN_W'(1) : base_seen;

        push           = accept && (seen_next > SEEN_W'(WINDOW));
        push_counts.gc = gc_next;
        push_counts.at = at_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= CLS_OTHER;
            end
            slot_reg <= '0;
            seen_reg <= '0;
            gc_reg   <= '0;
            at_reg   <= '0;
        end
        else if (accept)
        begin
            // A new sequence clears every other entry while the first byte lands in slot zero.
            for (int i = 0; i < WINDOW; i++)
            begin
                if (SLOT_W'(i) == base_slot)
                begin
                    ring_reg[i] <= cls;
                end
                else if (new_sequence)
                begin
                    ring_reg[i] <= CLS_OTHER;
                end
            end
            slot_reg <= slot_next;
            seen_reg <= seen_next;
            gc_reg   <= gc_next;
            at_reg   <= at_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/swgc_queue.sv
// Short queue of count pairs between the front end and the divider.
`default_nettype none

module swgc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire swgc_pkg::swgc_counts_t push_counts,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        not_empty,
    output swgc_pkg::swgc_counts_t      head
);
    import swgc_pkg::*;

    swgc_counts_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_counts;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/swgc_divider.sv
// Back end: one quotient bit per cycle of gc*65536/(gc+at), zero when either count is zero, then holds the result.
`default_nettype none

module swgc_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_not_empty,
    input  wire swgc_pkg::swgc_counts_t          q_head,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [swgc_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import swgc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [CNT_W:0]      rem_reg;
    logic [CNT_W:0]      den_reg;
    logic [FRAC_W-1:0]   quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                zero_reg;
    logic [CNT_W-1:0]    gc_reg, at_reg;
    logic [CNT_W+1:0]    rem_shift;
    logic                take;
    logic [CNT_W+COUNT_W-1:0] gc_wide, at_wide;
    logic [FRAC_W-1:0]   frac;

    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign rem_shift = {rem_reg, 1'b0};
    assign take      = (rem_shift >= {1'b0, den_reg});
    assign m_tvalid  = (state_reg == S_OUT);
    assign gc_wide   = {{COUNT_W{1'b0}}, gc_reg};
    assign at_wide   = {{COUNT_W{1'b0}}, at_reg};
    assign frac      = zero_reg ? '0 : quo_reg;
    assign m_tdata   = OUT_DATA_W'({at_wide[COUNT_W-1:0], gc_wide[COUNT_W-1:0], frac});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
            zero_reg  <= 1'b0;
            gc_reg    <= '0;
            at_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= '0;
                        rem_reg   <= {1'b0, q_head.gc};
                        den_reg   <= {1'b0, q_head.gc} + {1'b0, q_head.at};
                        quo_reg   <= '0;
                        zero_reg  <= (q_head.gc == '0) || (q_head.at == '0);
                        gc_reg    <= q_head.gc;
                        at_reg    <= q_head.at;
                    end
                end
                S_DIV:
                begin
                    // The remainder never exceeds the divisor, so it always fits back.
                    if (take)
                    begin
                        rem_reg <= (CNT_W+1)'(rem_shift - {1'b0, den_reg});
                    end
                    else
                    begin
                        rem_reg <= rem_shift[CNT_W:0];
                    end
                    quo_reg  <= {quo_reg[FRAC_W-2:0], take};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(FRAC_W - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_gc_fraction.sv
// Top level of the sliding-window C/G fraction block.
//
//  Group  Dir  Field bits (lowest first)                       Transaction
//  s_*    in   tdata: symbol[7:0]; tuser: new_sequence[0]      s_tvalid & s_tready
//  m_*    out  tdata: gc_fraction[15:0], gc_count[20:16],      m_tvalid & m_tready
//              at_count[25:21], zeros[31:26]
//
// The front end takes a byte in every cycle while its four-entry queue has room.
// The divider loads a count pair, works out 16 quotient bits and then presents the
// result until it is taken, so it takes a new pair only once the last result is gone.
// Reset clears the ring, counts, queue and divider state at once; no clearing pass.
// A stalled output holds the divider, and the queue absorbs count pairs until full.
`default_nettype none

module sliding_window_gc_fraction (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [swgc_pkg::IN_DATA_W-1:0]    s_tdata,  // symbol[7:0]
    input  wire logic                              s_tuser,  // new_sequence
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [swgc_pkg::OUT_DATA_W-1:0]        m_tdata   // gc_fraction, gc_count, at_count
);
    import swgc_pkg::*;

    logic          accept;
    logic          push;
    swgc_counts_t  push_counts;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    swgc_counts_t  q_head;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    swgc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .symbol       (s_tdata[SYMBOL_W-1:0]),
        .new_sequence (s_tuser),
        .push         (push),
        .push_counts  (push_counts)
    );

    swgc_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_counts (push_counts),
        .pop         (q_pop),
        .full        (q_full),
        .not_empty   (q_not_empty),
        .head        (q_head)
    );

    swgc_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/swgc_checker.sv
// Port-level checks for the sliding-window C/G fraction block, with its bind.
`default_nettype none

module swgc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [swgc_pkg::IN_DATA_W-1:0]   s_tdata,
    input wire logic                             s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [swgc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import swgc_pkg::*;

    // A result once offered stays offered until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before transaction");

    // The two counts never exceed the window between them.
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[20:16]} + {1'b0, m_tdata[25:21]}) <= 6'(WINDOW))
        else $error("counts exceed window");

    // With either count at zero the fraction must be zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[20:16] == 5'd0 || m_tdata[25:21] == 5'd0)
        |-> m_tdata[15:0] == 16'd0)
        else $error("non-zero fraction with an empty count");

    // Padding bits stay clear.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:26] == 6'd0)
        else $error("padding bits set");

endmodule

bind sliding_window_gc_fraction swgc_checker u_swgc_checker (.*);

`default_nettype wire
